FILE: hw/rtl/nbr_pkg.sv
// Package for the neighbor bandwidth reservation block: grid constants,
// operation codes, scheme codes and the call-count tier function.
// Used by neighbor_bandwidth_reservation and its checker.
`timescale 1ns / 1ps
`default_nettype none
package nbr_pkg;
  localparam int GridDim   = 16;
  localparam int NbrCount  = 6;
  localparam int CoordW    = $clog2(GridDim);
  localparam int CellW     = 2 * CoordW;
  localparam int Cells     = GridDim * GridDim;
  localparam int LinkDepth = Cells * NbrCount;
  localparam int LinkAw    = $clog2(LinkDepth);
  localparam int LinkW     = 1 + 2 * CoordW;

  localparam logic [1:0] OpLoad    = 2'd0;
  localparam logic [1:0] OpLink    = 2'd1;
  localparam logic [1:0] OpRead    = 2'd2;
  localparam logic [1:0] OpRequest = 2'd3;

  localparam logic [1:0] SchemeTwoHop = 2'd0;
  localparam logic [1:0] SchemeOneHop = 2'd1;
  localparam logic [1:0] SchemeDir    = 2'd2;

  localparam logic [15:0] CapacityReset = 16'd8192;

  function automatic logic [11:0] tier_of(input logic [15:0] count);
    if (count <= 16'd5)       tier_of = 12'd512;
    else if (count <= 16'd10) tier_of = 12'd1024;
    else if (count <= 16'd20) tier_of = 12'd2048;
    else                      tier_of = 12'd3072;
  endfunction
endpackage
`default_nettype wire

FILE: hw/rtl/neighbor_bandwidth_reservation.sv
// Neighbor bandwidth reservation admission, top level. Depends on nbr_pkg.
// Loads, link writes and reads pass from acceptance through S_CWAIT and S_EVAL to S_OUT.
// A scheme 0 request makes up to 42 link reads and 42 cell reads (each a read state and a
// wait state), 6 evaluations, then 6 commit writes; schemes 1 and 2 skip the second hop.
// One transaction is in flight at a time; the next can be accepted in the cycle after the result is taken.
// Reset sets the control registers, then a clearing pass zeroes all 1536 link and 256 cell entries.
`timescale 1ns / 1ps
`default_nettype none
module neighbor_bandwidth_reservation (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  op,
  input  wire logic [3:0]  cell_row,
  input  wire logic [3:0]  cell_col,
  input  wire logic [2:0]  slot,
  input  wire logic        link_valid,
  input  wire logic [3:0]  link_row,
  input  wire logic [3:0]  link_col,
  input  wire logic [7:0]  call_count,
  input  wire logic [15:0] used_bw,
  input  wire logic [2:0]  heading,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             accepted,
  output logic [11:0]      reserved_bw
);
  localparam int CW = nbr_pkg::CellW;
  localparam int LA = nbr_pkg::LinkAw;
  localparam int LW = nbr_pkg::LinkW;

  typedef enum logic [10:0] {
    S_CLEAR  = 11'b00000000001,
    S_IDLE   = 11'b00000000010,
    S_LRD    = 11'b00000000100,  // issue read of a first-hop link
    S_LWAIT  = 11'b00000001000,
    S_HRD    = 11'b00000010000,  // issue read of a second-hop link
    S_HWAIT  = 11'b00000100000,
    S_CRD    = 11'b00001000000,  // issue cell read
    S_CWAIT  = 11'b00010000000,
    S_EVAL   = 11'b00100000000,
    S_COMMIT = 11'b01000000000,
    S_OUT    = 11'b10000000000
  } state_t;

  state_t state;

  logic [15:0] capacity;
  logic [1:0]  scheme;

  // Memories.
  logic [LW-1:0]  link_mem [nbr_pkg::LinkDepth];
  logic [7:0]     cnt_mem  [nbr_pkg::Cells];
  logic [15:0]    used_mem [nbr_pkg::Cells];
  logic [11:0]    res_mem  [nbr_pkg::Cells];
  logic           link_we, cell_we, res_we;
  logic [LA-1:0]  link_waddr, link_raddr;
  logic [LW-1:0]  link_wdata, link_rdata;
  logic [CW-1:0]  cell_waddr, cell_raddr, res_waddr;
  logic [7:0]     cnt_wdata, cnt_rdata;
  logic [15:0]    used_wdata, used_rdata;
  logic [11:0]    res_wdata, res_rdata;

  always_ff @(posedge clk) begin
    if (link_we) link_mem[link_waddr] <= link_wdata;
    if (cell_we) begin
      cnt_mem[cell_waddr]  <= cnt_wdata;
      used_mem[cell_waddr] <= used_wdata;
    end
    if (res_we) res_mem[res_waddr] <= res_wdata;
    link_rdata <= link_mem[link_raddr];
    cnt_rdata  <= cnt_mem[cell_raddr];
    used_rdata <= used_mem[cell_raddr];
    res_rdata  <= res_mem[cell_raddr];
  end

  // Transaction registers.
  logic [1:0]    t_op;
  logic [CW-1:0] t_cell;
  logic          t_in_grid;
  logic [2:0]    t_slot;
  logic [2:0]    t_heading;
  logic [LW-1:0] t_link;
  logic [7:0]    t_count;
  logic [15:0]   t_used;

  logic [LA-1:0] clr_idx;
  logic [2:0]    k;          // first-hop index 0..5 (position in slot list)
  logic [2:0]    h;          // second-hop slot
  logic [CW-1:0] nb_cell;
  logic          hop2;       // current cell read is a second-hop count
  logic [15:0]   sum;
  logic [5:0]    tgt_valid;
  logic [CW-1:0] tgt [nbr_pkg::NbrCount];
  logic [11:0]   amt [nbr_pkg::NbrCount];
  logic [2:0]    nslots;
  logic          res_acc;
  logic [11:0]   res_bw;

  function automatic logic [2:0] slot_at(input logic [1:0] sch, input logic [2:0] hd,
                                         input logic [2:0] i);
    logic [2:0] r;
    r = i;
    if (sch == nbr_pkg::SchemeDir) begin
      if (hd == 3'd0)      r = (i == 3'd0) ? 3'd5 : i - 3'd1;
      else if (hd == 3'd5) r = (i == 3'd0) ? 3'd0 : i + 3'd3;
      else                 r = hd + i - 3'd1;
    end
    return r;
  endfunction

  function automatic logic [LA-1:0] link_addr(input logic [CW-1:0] c, input logic [2:0] s);
    logic [LA+2:0] a;
    a = {3'd0, c} * (LA + 3)'(nbr_pkg::NbrCount) + {{LA{1'b0}}, s};
    return a[LA-1:0];
  endfunction

  logic [CW-1:0] lk_cell;
  logic          lk_ok;
  assign lk_cell = link_rdata[CW-1:0];
  assign lk_ok   = link_rdata[LW-1];

  logic [11:0] tier;
  logic [16:0] room;     // capacity - used, sign in msb
  logic        room_neg;
  logic [11:0] want;
  assign tier = nbr_pkg::tier_of(scheme == nbr_pkg::SchemeTwoHop ? sum : {8'd0, t_count});
  assign room = {1'b0, capacity} - {1'b0, t_used};
  assign room_neg = room[16];
  assign want = (scheme == nbr_pkg::SchemeDir) ? {1'b0, tier[11:1]} : tier;

  logic [16:0] sum_add;
  assign sum_add = {1'b0, sum} + {9'd0, cnt_rdata};

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_OUT);
  assign accepted  = res_acc;
  assign reserved_bw = res_bw;
  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {16'd0, capacity} : {30'd0, scheme};

  always_comb begin
    link_we = 1'b0; link_waddr = clr_idx; link_wdata = '0;
    cell_we = 1'b0; cell_waddr = clr_idx[CW-1:0]; cnt_wdata = '0; used_wdata = '0;
    res_we = 1'b0; res_waddr = clr_idx[CW-1:0]; res_wdata = '0;
    link_raddr = link_addr(t_cell, slot_at(scheme, t_heading, k));
    cell_raddr = t_cell;
    case (state)
      S_CLEAR: begin
        link_we = 1'b1;
        cell_we = (clr_idx < LA'(nbr_pkg::Cells));
        res_we  = cell_we;
      end
      // The addressed cell is read at the accepting edge, for a reservation read.
      S_IDLE: cell_raddr = {cell_row, cell_col};
      S_HRD: link_raddr = link_addr(nb_cell, h);
      S_CRD: cell_raddr = nb_cell;
      S_COMMIT: begin
        res_we = tgt_valid[k];
        res_waddr = tgt[k];
        res_wdata = amt[k];
      end
      S_EVAL: begin
        if (t_op == nbr_pkg::OpLoad && t_in_grid) begin
          cell_we = 1'b1; cell_waddr = t_cell;
          cnt_wdata = t_count; used_wdata = t_used;
        end
        if (t_op == nbr_pkg::OpLink && t_in_grid && t_slot < 3'd6) begin
          link_we = 1'b1;
          link_waddr = link_addr(t_cell, t_slot);
          link_wdata = t_link;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr_idx <= '0;
      capacity <= nbr_pkg::CapacityReset;
      scheme <= nbr_pkg::SchemeTwoHop;
      res_acc <= 1'b0;
      res_bw <= '0;
    end else begin
      if (psel && penable && pwrite) begin
        if (paddr[2] == 1'b0) capacity <= pwdata[15:0];
        else scheme <= pwdata[1:0];
      end
      case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx == LA'(nbr_pkg::LinkDepth - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid) begin
            t_op <= op;
            t_cell <= {cell_row, cell_col};
            t_in_grid <= 1'b1;
            t_slot <= slot;
            t_heading <= heading;
            t_link <= {link_valid, link_row, link_col};
            t_count <= call_count;
            t_used <= used_bw;
            k <= '0;
            tgt_valid <= '0;
            res_acc <= 1'b0;
            res_bw <= '0;
            state <= (op == nbr_pkg::OpRequest) ? S_LRD : S_CWAIT;
            if (op == nbr_pkg::OpRequest) begin
              nslots <= (scheme == nbr_pkg::SchemeDir) ? 3'd3 : 3'd6;
              if (scheme > nbr_pkg::SchemeDir ||
                  (scheme == nbr_pkg::SchemeDir && heading > 3'd5))
                state <= S_OUT;
            end
          end
        end
        S_LRD: state <= S_LWAIT;
        S_LWAIT: begin
          nb_cell <= lk_cell;
          sum <= '0;
          h <= '0;
          hop2 <= 1'b0;
          if (!lk_ok) begin
            if (k + 1'b1 == nslots) begin
              k <= '0;
              state <= (tgt_valid != '0) ? S_COMMIT : S_OUT;
            end else begin
              k <= k + 1'b1;
              state <= S_LRD;
            end
          end else begin
            state <= (scheme == nbr_pkg::SchemeTwoHop) ? S_HRD : S_CRD;
          end
        end
        S_HRD: state <= S_HWAIT;
        S_HWAIT: begin
          if (lk_ok) begin
            tgt[k] <= nb_cell;    // park first-hop cell while reading count
            nb_cell <= lk_cell;
            hop2 <= 1'b1;
            state <= S_CRD;
          end else if (h == 3'd5) begin
            hop2 <= 1'b0;
            state <= S_CRD;
          end else begin
            h <= h + 1'b1;
            state <= S_HRD;
          end
        end
        S_CRD: state <= S_CWAIT;
        S_CWAIT: begin
          if (t_op != nbr_pkg::OpRequest) begin
            if (t_op == nbr_pkg::OpRead) res_bw <= res_rdata;
            state <= S_EVAL;
          end else if (hop2) begin
            sum <= sum_add[16] ? 16'hFFFF : sum_add[15:0];
            nb_cell <= tgt[k];
            hop2 <= 1'b0;
            if (h == 3'd5) state <= S_CRD;
            else begin
              h <= h + 1'b1;
              state <= S_HRD;
            end
          end else begin
            t_used <= used_rdata;
            t_count <= cnt_rdata;
            state <= S_EVAL;
          end
        end
        S_EVAL: begin
          if (t_op != nbr_pkg::OpRequest) state <= S_OUT;
          else if (room_neg || {5'd0, tier} > room) state <= S_OUT;
          else begin
            tgt[k] <= nb_cell;
            tgt_valid[k] <= 1'b1;
            amt[k] <= (scheme != nbr_pkg::SchemeTwoHop && {5'd0, want} > room)
                      ? room[11:0] : want;
            if (k + 1'b1 == nslots) begin
              k <= '0;
              state <= S_COMMIT;
            end else begin
              k <= k + 1'b1;
              state <= S_LRD;
            end
          end
        end
        S_COMMIT: begin
          res_acc <= 1'b1;
          if (k == 3'd5) state <= S_OUT;
          else k <= k + 1'b1;
        end
        S_OUT: if (out_ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

FILE: hw/rtl/nbr_checker.sv
// Port-level checker for neighbor_bandwidth_reservation, bound to the top.
// Depends on nbr_pkg only for the operation codes.
`timescale 1ns / 1ps
`default_nettype none
module nbr_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic        accepted,
  input wire logic [11:0] reserved_bw,
  input wire logic [1:0]  op
);
  a_no_in_while_out: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("input taken while result pending");
  a_out_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(accepted))
    else $error("result dropped");
  a_acc_req: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && op != nbr_pkg::OpRequest |=> !accepted)
    else $error("accepted on non-request");
  a_bw_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> reserved_bw <= 12'd3072) else $error("reserved out of range");
endmodule

bind neighbor_bandwidth_reservation nbr_checker u_nbr_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .accepted(accepted),
  .reserved_bw(reserved_bw), .op(op));
`default_nettype wire

FILE: tb/tb_neighbor_bandwidth_reservation.sv
// Self-checking testbench for neighbor_bandwidth_reservation: directed table,
// then phased random traffic checked against an in-bench admission predictor.
// Depends on nbr_pkg and the neighbor_bandwidth_reservation RTL.
`timescale 1ns / 1ps
module tb_neighbor_bandwidth_reservation;
  localparam logic [2:0] CapacityAddr = 3'd0;
  localparam logic [2:0] SchemeAddr   = 3'd4;
  localparam logic [1:0] SchemeNone   = 2'd3;
  localparam int StallLimit = 20000;
  localparam int ItemsPerPhase = 165;

  typedef struct {
    logic [1:0]  op;
    logic [3:0]  row;
    logic [3:0]  col;
    logic [2:0]  slot;
    logic        lvalid;
    logic [3:0]  lrow;
    logic [3:0]  lcol;
    logic [7:0]  count;
    logic [15:0] used;
    logic [2:0]  heading;
  } nbr_item_t;

  typedef struct {
    logic        admit;
    logic [11:0] rbw;
  } nbr_result_t;

  typedef struct {
    nbr_item_t   item;
    bit          typed;
    nbr_result_t res;
  } table_row_t;

  logic clk, rst;
  logic psel, penable, pwrite;
  logic [2:0] paddr;
  logic [31:0] pwdata, prdata;
  logic pready;
  logic in_valid, in_ready;
  logic [1:0] op;
  logic [3:0] cell_row, cell_col, link_row, link_col;
  logic [2:0] slot, heading;
  logic link_valid;
  logic [7:0] call_count;
  logic [15:0] used_bw;
  logic out_valid, out_ready, accepted;
  logic [11:0] reserved_bw;

  neighbor_bandwidth_reservation i_dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready),
    .op(op), .cell_row(cell_row), .cell_col(cell_col), .slot(slot),
    .link_valid(link_valid), .link_row(link_row), .link_col(link_col),
    .call_count(call_count), .used_bw(used_bw), .heading(heading),
    .out_valid(out_valid), .out_ready(out_ready),
    .accepted(accepted), .reserved_bw(reserved_bw)
  );

  // Predictor copy of the grid state and the registers.
  logic [15:0] pr_capacity;
  logic [1:0]  pr_scheme;
  logic [7:0]  pr_count [nbr_pkg::Cells];
  logic [15:0] pr_used  [nbr_pkg::Cells];
  logic [11:0] pr_resv  [nbr_pkg::Cells];
  logic        pr_lv    [nbr_pkg::LinkDepth];
  logic [3:0]  pr_lr    [nbr_pkg::LinkDepth];
  logic [3:0]  pr_lc    [nbr_pkg::LinkDepth];

  nbr_result_t expected_results [$];
  int errors = 0;
  bit idle_on = 1;
  int hold_request = 0;

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  function automatic int nbr_target(int cidx, int s);
    int idx;
    idx = cidx * nbr_pkg::NbrCount + s;
    if (!pr_lv[idx]) return -1;
    return pr_lr[idx] * nbr_pkg::GridDim + pr_lc[idx];
  endfunction

  function automatic logic [11:0] band_tier(int cnt);
    if (cnt <= 5) return 12'd512;
    if (cnt <= 10) return 12'd1024;
    if (cnt <= 20) return 12'd2048;
    return 12'd3072;
  endfunction

  function automatic logic admit_request(int cidx, logic [2:0] hd);
    int sl [nbr_pkg::NbrCount];
    int tgt [nbr_pkg::NbrCount];
    int amt [nbr_pkg::NbrCount];
    int nsl, nv, t, sum, room, tier, a;
    nv = 0;
    if (pr_scheme == SchemeNone) return 0;
    if (pr_scheme == nbr_pkg::SchemeDir) begin
      if (hd == 0) begin
        sl[0] = 5; sl[1] = 0; sl[2] = 1;
      end else if (hd == 5) begin
        sl[0] = 0; sl[1] = 4; sl[2] = 5;
      end else if (hd <= 4) begin
        sl[0] = hd - 1; sl[1] = hd; sl[2] = hd + 1;
      end else return 0;
      nsl = 3;
    end else begin
      for (int k = 0; k < nbr_pkg::NbrCount; k++) sl[k] = k;
      nsl = nbr_pkg::NbrCount;
    end
    for (int k = 0; k < nsl; k++) begin
      t = nbr_target(cidx, sl[k]);
      if (t >= 0) begin
        if (pr_scheme == nbr_pkg::SchemeTwoHop) begin
          sum = 0;
          for (int n = 0; n < nbr_pkg::NbrCount; n++)
            if (nbr_target(t, n) >= 0) sum += pr_count[nbr_target(t, n)];
          if (sum > 65535) sum = 65535;
        end else sum = pr_count[t];
        tier = band_tier(sum);
        room = int'(pr_capacity) - int'(pr_used[t]);
        if (tier > room) return 0;
        a = (pr_scheme == nbr_pkg::SchemeDir) ? tier / 2 : tier;
        if (pr_scheme != nbr_pkg::SchemeTwoHop && a > room) a = room;
        tgt[nv] = t;
        amt[nv] = a;
        nv++;
      end
    end
    if (nv == 0) return 0;
    for (int k = 0; k < nv; k++) pr_resv[tgt[k]] = amt[k][11:0];
    return 1;
  endfunction

  function automatic nbr_result_t apply_item(nbr_item_t it);
    nbr_result_t r;
    int cidx, idx;
    r.admit = 0;
    r.rbw = '0;
    cidx = it.row * nbr_pkg::GridDim + it.col;
    case (it.op)
      nbr_pkg::OpLoad: begin
        pr_count[cidx] = it.count;
        pr_used[cidx] = it.used;
      end
      nbr_pkg::OpLink: begin
        if (it.slot < nbr_pkg::NbrCount) begin
          idx = cidx * nbr_pkg::NbrCount + it.slot;
          pr_lv[idx] = it.lvalid;
          pr_lr[idx] = it.lrow;
          pr_lc[idx] = it.lcol;
        end
      end
      nbr_pkg::OpRead: r.rbw = pr_resv[cidx];
      default: r.admit = admit_request(cidx, it.heading);
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what);
    $display("mismatch at %0t: %s", $time, what);
    errors++;
  endtask

  // Drives one transaction and holds it until the block takes it.
  task automatic send_item(nbr_item_t it, bit typed, nbr_result_t want);
    nbr_result_t got;
    if (idle_on && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_valid <= 1'b1;
    op <= it.op; cell_row <= it.row; cell_col <= it.col; slot <= it.slot;
    link_valid <= it.lvalid; link_row <= it.lrow; link_col <= it.lcol;
    call_count <= it.count; used_bw <= it.used; heading <= it.heading;
    do @(posedge clk); while (!in_ready);
    got = apply_item(it);
    expected_results.push_back(typed ? want : got);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] addr, logic [31:0] data);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (addr == CapacityAddr) pr_capacity = data[15:0];
    else pr_scheme = data[1:0];
    @(posedge clk);
  endtask

  function automatic nbr_item_t random_item();
    nbr_item_t it;
    bit noise;
    int pick;
    noise = ($urandom_range(0, 99) < 12);
    pick = $urandom_range(0, 99);
    it.op = pick < 25 ? nbr_pkg::OpLoad : pick < 50 ? nbr_pkg::OpLink :
            pick < 62 ? nbr_pkg::OpRead : nbr_pkg::OpRequest;
    it.row = noise ? 4'($urandom_range(0, 15)) : 4'($urandom_range(0, 3));
    it.col = noise ? 4'($urandom_range(0, 15)) : 4'($urandom_range(0, 3));
    it.slot = noise ? 3'($urandom_range(0, 7)) : 3'($urandom_range(0, 5));
    it.lvalid = noise ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 9) != 0);
    it.lrow = noise ? 4'($urandom_range(0, 15)) : 4'($urandom_range(0, 3));
    it.lcol = noise ? 4'($urandom_range(0, 15)) : 4'($urandom_range(0, 3));
    case ($urandom_range(0, 4))
      0: it.count = 8'($urandom_range(0, 5));
      1: it.count = 8'($urandom_range(6, 10));
      2: it.count = 8'($urandom_range(11, 20));
      3: it.count = 8'($urandom_range(0, 2));
      default: it.count = 8'($urandom_range(0, 255));
    endcase
    it.used = noise ? 16'($urandom_range(0, 65535)) : 16'($urandom_range(0, pr_capacity / 3));
    it.heading = noise ? 3'($urandom_range(0, 7)) : 3'($urandom_range(0, 5));
    return it;
  endfunction

  function automatic nbr_item_t make_item(logic [1:0] o, int r, int c, int s, int lv,
                                          int lr, int lc, int cnt, int u, int hd);
    nbr_item_t it;
    it.op = o; it.row = 4'(r); it.col = 4'(c); it.slot = 3'(s); it.lvalid = 1'(lv);
    it.lrow = 4'(lr); it.lcol = 4'(lc); it.count = 8'(cnt); it.used = 16'(u);
    it.heading = 3'(hd);
    return it;
  endfunction

  // Result checker.
  always @(posedge clk) begin
    nbr_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result with nothing expected");
      end else begin
        want = expected_results.pop_front();
        if (accepted !== want.admit)
          report_mismatch($sformatf("accepted %0b, want %0b", accepted, want.admit));
        if (reserved_bw !== want.rbw)
          report_mismatch($sformatf("reserved_bw %0d, want %0d", reserved_bw, want.rbw));
      end
    end
  end

  // Receiver back-pressure: random bursts plus one long hold-off on request.
  initial begin
    int stall;
    stall = 0;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request != 0) begin
        stall = hold_request;
        hold_request = 0;
      end else if (stall == 0 && idle_on && $urandom_range(0, 15) == 0) begin
        stall = $urandom_range(1, 12);
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        stall--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog on cycles without any transaction.
  always @(posedge clk) begin
    int quiet;
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= StallLimit) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin
    table_row_t directed [$];
    nbr_result_t none;
    logic [15:0] caps [10] = '{16'hFFFF, 16'd0, 16'd4000, 16'd6000, 16'd9000,
                              16'd12000, 16'd7000, 16'd20000, 16'd8192, 16'd3500};
    logic [1:0] schemes [10] = '{nbr_pkg::SchemeOneHop, nbr_pkg::SchemeDir,
                                 nbr_pkg::SchemeTwoHop, nbr_pkg::SchemeDir,
                                 nbr_pkg::SchemeOneHop, nbr_pkg::SchemeTwoHop, SchemeNone,
                                 nbr_pkg::SchemeDir, nbr_pkg::SchemeOneHop,
                                 nbr_pkg::SchemeTwoHop};
    rst = 1'b1;
    psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
    in_valid = 0; op = '0; cell_row = '0; cell_col = '0; slot = '0; link_valid = 0;
    link_row = '0; link_col = '0; call_count = '0; used_bw = '0; heading = '0;
    pr_capacity = nbr_pkg::CapacityReset;
    pr_scheme = nbr_pkg::SchemeTwoHop;
    for (int i = 0; i < nbr_pkg::Cells; i++) begin
      pr_count[i] = '0; pr_used[i] = '0; pr_resv[i] = '0;
    end
    for (int i = 0; i < nbr_pkg::LinkDepth; i++) begin
      pr_lv[i] = 0; pr_lr[i] = '0; pr_lc[i] = '0;
    end
    none.admit = 0;
    none.rbw = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed table; typed rows carry results readable by inspection.
    directed.push_back('{make_item(nbr_pkg::OpRead, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1,
                         '{0, 12'd0}});
    directed.push_back('{make_item(nbr_pkg::OpRequest, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1,
                         '{0, 12'd0}});
    directed.push_back('{make_item(nbr_pkg::OpLoad, 0, 1, 0, 0, 0, 0, 255, 65535, 0), 1,
                         none});
    directed.push_back('{make_item(nbr_pkg::OpLink, 0, 0, 0, 1, 0, 1, 0, 0, 0), 1, none});
    directed.push_back('{make_item(nbr_pkg::OpRequest, 0, 0, 0, 0, 0, 0, 0, 0, 7), 1,
                         '{0, 12'd0}});
    directed.push_back('{make_item(nbr_pkg::OpLoad, 0, 1, 0, 0, 0, 0, 0, 0, 0), 1, none});
    directed.push_back('{make_item(nbr_pkg::OpRequest, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1,
                         '{1, 12'd0}});
    directed.push_back('{make_item(nbr_pkg::OpRead, 0, 1, 0, 0, 0, 0, 0, 0, 0), 1,
                         '{0, 12'd512}});
    directed.push_back('{make_item(nbr_pkg::OpLink, 0, 0, 6, 1, 15, 15, 0, 0, 0), 1, none});
    directed.push_back('{make_item(nbr_pkg::OpLink, 0, 0, 7, 1, 15, 15, 0, 0, 0), 1, none});
    directed.push_back('{make_item(nbr_pkg::OpLoad, 15, 15, 0, 0, 0, 0, 21, 5120, 0), 1,
                         none});
    directed.push_back('{make_item(nbr_pkg::OpLink, 15, 15, 5, 1, 15, 15, 0, 0, 0), 1,
                         none});
    directed.push_back('{make_item(nbr_pkg::OpLink, 15, 15, 2, 1, 0, 0, 0, 0, 0), 1, none});
    directed.push_back('{make_item(nbr_pkg::OpLink, 0, 0, 1, 1, 15, 15, 0, 0, 0), 1, none});
    directed.push_back('{make_item(nbr_pkg::OpRequest, 15, 15, 0, 0, 0, 0, 0, 0, 3), 0,
                         none});
    directed.push_back('{make_item(nbr_pkg::OpRequest, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0,
                         none});
    directed.push_back('{make_item(nbr_pkg::OpRead, 15, 15, 0, 0, 0, 0, 0, 0, 0), 0, none});
    directed.push_back('{make_item(nbr_pkg::OpLoad, 1, 1, 0, 0, 0, 0, 8, 8192, 0), 1,
                         none});
    directed.push_back('{make_item(nbr_pkg::OpLink, 0, 0, 3, 1, 1, 1, 0, 0, 0), 1, none});
    directed.push_back('{make_item(nbr_pkg::OpRequest, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1,
                         '{0, 12'd0}});
    directed.push_back('{make_item(nbr_pkg::OpLink, 0, 0, 3, 0, 1, 1, 0, 0, 0), 1, none});
    directed.push_back('{make_item(nbr_pkg::OpRequest, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0,
                         none});
    directed.push_back('{make_item(nbr_pkg::OpRead, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0, none});
    foreach (directed[i]) send_item(directed[i].item, directed[i].typed, directed[i].res);

    for (int ph = 0; ph < 10; ph++) begin
      drain_results();
      write_reg(CapacityAddr, {16'd0, caps[ph]});
      write_reg(SchemeAddr, {30'd0, schemes[ph]});
      idle_on = (ph < 8);
      for (int n = 0; n < ItemsPerPhase; n++) begin
        if (ph == 1 && n == 20) hold_request = 300;
        if (ph == 3 && n == 50) drain_results();
        send_item(random_item(), 0, none);
      end
    end

    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
